@@ rtl/ddhp_pkg.sv @@
package ddhp_pkg;

    // Fixed-point format of positions, angles and speeds.
    localparam int FRAC_BITS = 4;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int PID_LIMIT = 1600;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int POS_W   = 24;
    localparam int HEAD_W  = 13;
    localparam int SPD_W   = 15;
    localparam int WHEEL_W = 16;
    localparam int PID_W   = 12;
    localparam int GAIN_W  = 16;
    localparam int WGT_W   = 8;
    localparam int PWIN_W  = 16;
    localparam int AWIN_W  = 13;
    localparam int SPIN_W  = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Internal datapath widths.
    localparam int LAT_W  = POS_W + 2;      // position error and its negation
    localparam int HD_W   = HEAD_W + 2;     // heading differences
    localparam int AERR_W = HEAD_W + 1;     // absolute angle error
    localparam int E_W    = POS_W + 2;      // blended error
    localparam int MA_W   = E_W + 2;        // multiplier operand A (signed)
    localparam int MB_W   = GAIN_W + 1;     // multiplier operand B (signed, always >= 0)
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;

    // Stream word widths.
    localparam int IN_BITS  = CMD_W + 4 * POS_W + 2 * HEAD_W + SPD_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * WHEEL_W + 1 + PID_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_IDLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LINE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROT  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HD_WEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_WIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_WIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SPEED = 3'd7;

    // Heading constants.
    localparam logic signed [HEAD_W-1:0] HEAD_0   = '0;
    localparam logic signed [HEAD_W-1:0] HEAD_90  = HEAD_W'(90 * ONE);
    localparam logic signed [HEAD_W-1:0] HEAD_M90 = HEAD_W'(-90 * ONE);
    localparam logic signed [HEAD_W-1:0] HEAD_180 = HEAD_W'(180 * ONE);
    localparam logic signed [HD_W-1:0]   HEAD_360 = HD_W'(360 * ONE);
    localparam logic signed [HD_W-1:0]   PH_LOW   = HD_W'(-100 * ONE);

    // Multiplier operand pair.
    typedef struct packed {
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
    } mul_op_t;

endpackage

@@ rtl/ddhp_mul.sv @@
module ddhp_mul
    import ddhp_pkg::*;
(
    input  logic                     aclk,
    input  mul_op_t                  op,
    output logic signed [PROD_W-1:0] prod_reg
);

    // Shared signed multiplier with a registered product.
    always_ff @(posedge aclk) begin
        prod_reg <= op.a * op.b;
    end

endmodule

@@ rtl/differential_drive_heading_pid_unit.sv @@
// Heading and lateral PID steering for a differential-drive vehicle.
// Input channel s_*: one word per control update carrying the command,
// target pose, current pose and planned forward speed. Result channel
// m_*: one word per input word with the wheel speeds, the arrived flag
// and the saturated PID correction.
// Configuration: gains, weights, stop windows and spin speed are written
// through cfg_wr_en / cfg_index / cfg_wdata; the user writes them only while
// the block is idle, which the block itself does not enforce.
// Sequencing: all products go through one 28x17 multiplier under a small sequencer
// that takes one word at a time; s_tready rises again in the same cycle as m_tvalid.
// s_tready is high only while the sequencer is idle.
// A finished result sits in the output register; if the receiver stalls
// and the next result is ready, the sequencer waits in its last step
// until the output register is free.
// Reset (aresetn low, synchronous) restores the register defaults and
// clears the latched target, the PID error history and the held wheel
// speeds; no clearing pass is needed.
module differential_drive_heading_pid_unit
    import ddhp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // From bit 0: cmd, goal_x, goal_y, goal_heading, pose_x, pose_y,
    // pose_heading, forward_speed, zero padding.
    input  logic [IN_W-1:0]      s_tdata,
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // From bit 0: left_speed, right_speed, arrived, correction, zero padding.
    output logic [OUT_W-1:0]     m_tdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ERR   = 4'd1;
    localparam logic [3:0] ST_MLAT  = 4'd2;
    localparam logic [3:0] ST_MHD   = 4'd3;
    localparam logic [3:0] ST_BLEND = 4'd4;
    localparam logic [3:0] ST_DIFF  = 4'd5;
    localparam logic [3:0] ST_MP    = 4'd6;
    localparam logic [3:0] ST_MI    = 4'd7;
    localparam logic [3:0] ST_MD    = 4'd8;
    localparam logic [3:0] ST_SUM   = 4'd9;
    localparam logic [3:0] ST_PID   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    localparam int Q_W = ACC_W - 8;
    localparam logic signed [Q_W-1:0] Q_HI = Q_W'(PID_LIMIT);
    localparam logic signed [Q_W-1:0] Q_LO = Q_W'(-PID_LIMIT);
    localparam logic signed [PID_W-1:0] PID_HI = PID_W'(PID_LIMIT);
    localparam logic signed [PID_W-1:0] PID_LO = PID_W'(-PID_LIMIT);

    // Saturate a 17-bit sum to a 16-bit wheel command.
    function automatic logic signed [WHEEL_W-1:0] sat_wheel(
        input logic signed [WHEEL_W:0] v
    );
        logic signed [WHEEL_W-1:0] r;
        if (v[WHEEL_W] != v[WHEEL_W-1]) begin
            r = v[WHEEL_W] ? {1'b1, {(WHEEL_W-1){1'b0}}} : {1'b0, {(WHEEL_W-1){1'b1}}};
        end else begin
            r = v[WHEEL_W-1:0];
        end
        return r;
    endfunction

    // Input word fields.
    logic [CMD_W-1:0]         in_cmd;
    logic signed [POS_W-1:0]  in_goal_x, in_goal_y, in_pose_x, in_pose_y;
    logic signed [HEAD_W-1:0] in_goal_heading, in_pose_heading;
    logic signed [SPD_W-1:0]  in_forward_speed;

    assign in_cmd           = s_tdata[1:0];
    assign in_goal_x        = s_tdata[25:2];
    assign in_goal_y        = s_tdata[49:26];
    assign in_goal_heading  = s_tdata[62:50];
    assign in_pose_x        = s_tdata[86:63];
    assign in_pose_y        = s_tdata[110:87];
    assign in_pose_heading  = s_tdata[123:111];
    assign in_forward_speed = s_tdata[138:124];

    // Configuration registers.
    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [WGT_W-1:0]  lat_weight_reg, hd_weight_reg;
    logic [PWIN_W-1:0] pos_win_reg;
    logic [AWIN_W-1:0] ang_win_reg;
    logic [SPIN_W-1:0] spin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg     <= GAIN_W'(256);
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            lat_weight_reg <= WGT_W'(141);
            hd_weight_reg  <= WGT_W'(115);
            pos_win_reg    <= PWIN_W'(112);
            ang_win_reg    <= AWIN_W'(160);
            spin_reg       <= SPIN_W'(2094);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAIN_P:     gain_p_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:     gain_i_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:     gain_d_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_LAT_WEIGHT: lat_weight_reg <= cfg_wdata[WGT_W-1:0];
                CFG_HD_WEIGHT:  hd_weight_reg  <= cfg_wdata[WGT_W-1:0];
                CFG_POS_WIN:    pos_win_reg    <= cfg_wdata[PWIN_W-1:0];
                CFG_ANG_WIN:    ang_win_reg    <= cfg_wdata[AWIN_W-1:0];
                CFG_SPIN_SPEED: spin_reg       <= cfg_wdata[SPIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and persistent state.
    logic [3:0] state_reg, state_next;
    logic signed [POS_W-1:0]  held_gx_reg, held_gy_reg;
    logic signed [HEAD_W-1:0] held_gh_reg;
    logic signed [E_W-1:0]    blended_reg, blended_next;
    logic signed [E_W-1:0]    e1_reg, e2_reg;
    logic signed [WHEEL_W-1:0] held_left_reg, held_right_reg;
    logic                     m_tvalid_reg;
    logic [OUT_W-1:0]         m_tdata_reg;

    // Per-item working registers.
    logic [CMD_W-1:0]          cmd_reg;
    logic signed [POS_W-1:0]   px_reg, py_reg;
    logic signed [HEAD_W-1:0]  ph_reg;
    logic signed [SPD_W-1:0]   fs_reg;
    logic signed [LAT_W-1:0]   ex_reg, ey_reg, lat_reg;
    logic signed [HD_W-1:0]    hdiff_reg;
    logic [AERR_W-1:0]         aerr_reg;
    logic                      sel_reg;
    logic signed [E_W:0]       dp_reg;
    logic signed [E_W+1:0]     dd_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PID_W-1:0]   pid_reg;

    logic in_fire, out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Error terms from the latched target and the current pose.
    logic signed [LAT_W-1:0] gx_w, gy_w, px_w, py_w;
    logic signed [LAT_W-1:0] ex_c, ey_c, nex_c, ney_c, lat_c;
    logic signed [HD_W-1:0]  gh_w, ph_w, hd_c, ph_mag, ph_tr, d_c, d_mag;
    logic                    sel_c;

    always_comb begin
        gx_w  = LAT_W'(held_gx_reg);
        gy_w  = LAT_W'(held_gy_reg);
        px_w  = LAT_W'(px_reg);
        py_w  = LAT_W'(py_reg);
        ex_c  = gx_w - px_w;
        ey_c  = gy_w - py_w;
        nex_c = px_w - gx_w;
        ney_c = py_w - gy_w;
        gh_w  = HD_W'(held_gh_reg);
        ph_w  = HD_W'(ph_reg);
        // Heading difference, with the pose wrapped by a full turn at 180 degrees.
        if (held_gh_reg == HEAD_180 && ph_reg < 0) begin
            hd_c = gh_w - ph_w - HEAD_360;
        end else begin
            hd_c = gh_w - ph_w;
        end
        // Angle error: below -100 degrees the pose magnitude cut to whole degrees is used.
        ph_mag = ph_w[HD_W-1] ? -ph_w : ph_w;
        ph_tr  = {ph_mag[HD_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
        d_c    = (ph_w >= PH_LOW) ? (gh_w - ph_w) : (gh_w - ph_tr);
        d_mag  = d_c[HD_W-1] ? -d_c : d_c;
        // Lateral term chosen by the target heading.
        sel_c = 1'b1;
        lat_c = '0;
        if (held_gh_reg == HEAD_0) begin
            lat_c = ey_c;
        end else if (held_gh_reg == HEAD_180) begin
            lat_c = ney_c;
        end else if (held_gh_reg == HEAD_90) begin
            lat_c = nex_c;
        end else if (held_gh_reg == HEAD_M90) begin
            lat_c = ex_c;
        end else begin
            sel_c = 1'b0;
        end
    end

    // Operand selection for the shared multiplier.
    mul_op_t mul_op;
    logic signed [PROD_W-1:0] prod_reg;

    always_comb begin
        mul_op.a = '0;
        mul_op.b = '0;
        case (state_reg)
            ST_MLAT: begin
                mul_op.a = MA_W'(lat_reg);
                mul_op.b = MB_W'(lat_weight_reg);
            end
            ST_MHD: begin
                mul_op.a = MA_W'(hdiff_reg);
                mul_op.b = MB_W'(hd_weight_reg);
            end
            ST_MP: begin
                mul_op.a = MA_W'(dp_reg);
                mul_op.b = MB_W'(gain_p_reg);
            end
            ST_MI: begin
                mul_op.a = MA_W'(blended_reg);
                mul_op.b = MB_W'(gain_i_reg);
            end
            ST_MD: begin
                mul_op.a = MA_W'(dd_reg);
                mul_op.b = MB_W'(gain_d_reg);
            end
            default: ;
        endcase
    end

    ddhp_mul u_mul (
        .aclk     (aclk),
        .op       (mul_op),
        .prod_reg (prod_reg)
    );

    // Accumulator sum and blend result (floor of the sum over 256).
    logic signed [ACC_W-1:0] acc_sum;
    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    always_comb begin
        blended_next = blended_reg;
        if (sel_reg) begin
            blended_next = acc_sum[8 +: E_W];
        end
    end

    // PID output: floor over 256 and saturation.
    logic signed [Q_W-1:0]   pid_q;
    logic signed [PID_W-1:0] pid_c;

    always_comb begin
        pid_q = acc_reg[ACC_W-1:8];
        if (pid_q > Q_HI) begin
            pid_c = PID_HI;
        end else if (pid_q < Q_LO) begin
            pid_c = PID_LO;
        end else begin
            pid_c = pid_q[PID_W-1:0];
        end
    end

    // Wheel commands and stop windows.
    logic signed [WHEEL_W-1:0] fs_w, vx_w, left_c, right_c;
    logic signed [LAT_W-1:0]   pw_pos, pw_neg;
    logic [AERR_W-1:0]         aw_w;
    logic                      in_pos_win, arrived_c;

    always_comb begin
        fs_w   = WHEEL_W'(fs_reg);
        vx_w   = fs_w[WHEEL_W-1] ? -fs_w : fs_w;
        pw_pos = LAT_W'(pos_win_reg);
        pw_neg = -pw_pos;
        aw_w   = AERR_W'(ang_win_reg);
        in_pos_win = (ex_reg < pw_pos) && (ex_reg > pw_neg) &&
                     (ey_reg < pw_pos) && (ey_reg > pw_neg);
        left_c    = held_left_reg;
        right_c   = held_right_reg;
        arrived_c = 1'b0;
        case (cmd_reg)
            CMD_LINE: begin
                if (in_pos_win && aerr_reg < aw_w) begin
                    left_c    = '0;
                    right_c   = '0;
                    arrived_c = 1'b1;
                end else begin
                    left_c  = sat_wheel((WHEEL_W+1)'(vx_w) + (WHEEL_W+1)'(pid_reg));
                    right_c = sat_wheel((WHEEL_W+1)'(vx_w) - (WHEEL_W+1)'(pid_reg));
                end
            end
            CMD_ROT: begin
                if (aerr_reg <= aw_w) begin
                    left_c    = '0;
                    right_c   = '0;
                    arrived_c = 1'b1;
                end else begin
                    left_c  = WHEEL_W'(spin_reg);
                    right_c = -WHEEL_W'(spin_reg);
                end
            end
            default: ;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_ERR;
            ST_ERR:   state_next = ST_MLAT;
            ST_MLAT:  state_next = ST_MHD;
            ST_MHD:   state_next = ST_BLEND;
            ST_BLEND: state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MP;
            ST_MP:    state_next = ST_MI;
            ST_MI:    state_next = ST_MD;
            ST_MD:    state_next = ST_SUM;
            ST_SUM:   state_next = ST_PID;
            ST_PID:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state, held target, error history and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_gx_reg    <= '0;
            held_gy_reg    <= '0;
            held_gh_reg    <= '0;
            blended_reg    <= '0;
            e1_reg         <= '0;
            e2_reg         <= '0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_fire && (in_cmd == CMD_LINE || in_cmd == CMD_ROT)) begin
                held_gx_reg <= in_goal_x;
                held_gy_reg <= in_goal_y;
                held_gh_reg <= in_goal_heading;
            end
            if (state_reg == ST_BLEND) begin
                blended_reg <= blended_next;
            end
            if (state_reg == ST_DIFF) begin
                e2_reg <= e1_reg;
                e1_reg <= blended_reg;
            end
            if (state_reg == ST_OUT && out_free) begin
                held_left_reg  <= left_c;
                held_right_reg <= right_c;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the current word.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg <= in_cmd;
            px_reg  <= in_pose_x;
            py_reg  <= in_pose_y;
            ph_reg  <= in_pose_heading;
            fs_reg  <= in_forward_speed;
        end
        if (state_reg == ST_ERR) begin
            ex_reg    <= ex_c;
            ey_reg    <= ey_c;
            lat_reg   <= lat_c;
            sel_reg   <= sel_c;
            hdiff_reg <= hd_c;
            aerr_reg  <= {d_mag[AERR_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
        end
        if (state_reg == ST_DIFF) begin
            dp_reg <= (E_W+1)'(blended_reg) - (E_W+1)'(e1_reg);
            dd_reg <= (E_W+2)'(blended_reg) - ((E_W+2)'(e1_reg) <<< 1) + (E_W+2)'(e2_reg);
        end
        case (state_reg)
            ST_MHD, ST_MI:            acc_reg <= ACC_W'(prod_reg);
            ST_BLEND, ST_MD, ST_SUM:  acc_reg <= acc_sum;
            default: ;
        endcase
        if (state_reg == ST_PID) begin
            pid_reg <= pid_c;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= OUT_W'({pid_reg, arrived_c, right_c, left_c});
        end
    end

`ifndef SYNTHESIS
    // A word is taken only once per pass of the sequencer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input accepted while the sequencer is busy");

    // The correction never leaves the PID limits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[44:33]) <= PID_HI &&
                      $signed(m_tdata[44:33]) >= PID_LO))
        else $error("correction outside the PID limits");

    // An arrived result always commands both wheels to stop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == 32'd0))
        else $error("arrived result with nonzero wheel speed");

    // A new result is loaded only when the sequencer leaves its last step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");
`endif

endmodule
